/* hw/rtl/cwws_pkg.sv */
`default_nettype none
package cwws_pkg;

	// Table geometry
	localparam int MAX_WAYPOINTS = 4096;
	localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);

	// Field widths
	localparam int REQ_W     = 2;
	localparam int ENTRY_W   = 12;
	localparam int COORD_W   = 24;
	localparam int RADIUS_W  = 8;
	localparam int KIND_W    = 2;
	localparam int DIST_W    = 50;
	localparam int DSQ_W     = 2 * COORD_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b1;
	localparam logic [RADIUS_W-1:0]  RADIUS_AT_RESET = 8'd20;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TRACK   = 2'd2;

	// Result codes
	localparam logic [KIND_W-1:0] RK_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] RK_FOUND = 2'd1;
	localparam logic [KIND_W-1:0] RK_EMPTY = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic mod_start;
		logic mod_sel;     // 0: tracked index, 1: search radius
		logic load_tm;
		logic init_acq;
		logic init_track;
		logic issue;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic n_zero;
		logic mod_done;
		logic scan_last;
		logic pipe_empty;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* hw/rtl/cwws_req_if.sv */
`default_nettype none
interface cwws_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [cwws_pkg::REQ_W-1:0]           req_type;
	logic [cwws_pkg::ENTRY_W-1:0]         entry_index;
	logic signed [cwws_pkg::COORD_W-1:0]  wpt_x;
	logic signed [cwws_pkg::COORD_W-1:0]  wpt_y;
	logic signed [cwws_pkg::COORD_W-1:0]  car_x;
	logic signed [cwws_pkg::COORD_W-1:0]  car_y;

	modport source (output valid, req_type, entry_index, wpt_x, wpt_y, car_x, car_y,
		input ready);
	modport sink (input valid, req_type, entry_index, wpt_x, wpt_y, car_x, car_y,
		output ready);
endinterface
`default_nettype wire

/* hw/rtl/cwws_rsp_if.sv */
`default_nettype none
interface cwws_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cwws_pkg::KIND_W-1:0]   result_kind;
	logic [cwws_pkg::ENTRY_W-1:0]  closest_index;
	logic [cwws_pkg::DIST_W-1:0]   min_dist_sq;

	modport source (output valid, result_kind, closest_index, min_dist_sq, input ready);
	modport sink (input valid, result_kind, closest_index, min_dist_sq, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cwws_ram.sv */
`default_nettype none
module cwws_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/cwws_mod.sv */
`default_nettype none
module cwws_mod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cwws_pkg::IDX_W-1:0]  dividend,
	input  wire logic [cwws_pkg::CNT_W-1:0]  divisor,
	output logic                             done,
	output logic      [cwws_pkg::IDX_W-1:0]  rem
);
	import cwws_pkg::*;

	localparam int STEP_W = $clog2(IDX_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  quo_q;
	logic [CNT_W-1:0]  trial;
	logic [CNT_W-1:0]  rem_next;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q[CNT_W-2:0], quo_q[IDX_W-1]};
		rem_next = (trial >= divisor) ? (trial - divisor) : trial;
	end

	// Control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(IDX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and shifting dividend
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[IDX_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q[IDX_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/cwws_dp.sv */
`default_nettype none
module cwws_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cwws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cwws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic [cwws_pkg::REQ_W-1:0]          req_type,
	input  wire logic [cwws_pkg::ENTRY_W-1:0]        entry_index,
	input  wire logic signed [cwws_pkg::COORD_W-1:0] wpt_x,
	input  wire logic signed [cwws_pkg::COORD_W-1:0] wpt_y,
	input  wire logic signed [cwws_pkg::COORD_W-1:0] car_x,
	input  wire logic signed [cwws_pkg::COORD_W-1:0] car_y,
	input  wire logic                                rsp_ready,
	input  wire cwws_pkg::cmd_t                      cmd,
	output cwws_pkg::sts_t                           sts,
	output logic                                     rsp_valid,
	output logic [cwws_pkg::KIND_W-1:0]              result_kind,
	output logic [cwws_pkg::ENTRY_W-1:0]             closest_index,
	output logic [cwws_pkg::DIST_W-1:0]              min_dist_sq
);
	import cwws_pkg::*;

	localparam int RAM_W = 2 * COORD_W;

	// Configuration and persistent state
	logic [CNT_W-1:0]    count_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [IDX_W-1:0]    tracked_q;

	// Item context
	logic [KIND_W-1:0]          kind_q;
	logic signed [COORD_W-1:0]  car_x_q;
	logic signed [COORD_W-1:0]  car_y_q;

	// Scan control
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] remain_q;
	logic [IDX_W-1:0] tm_q;

	// Running minimum
	logic             have_q;
	logic [DSQ_W-1:0] best_q;
	logic [IDX_W-1:0] win_q;

	// Distance pipeline
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]       idx_s1, idx_s2, idx_s3, idx_s4;
	logic [COORD_W-1:0]     ax_s2, ay_s2;
	logic [2*COORD_W-1:0]   sqx_s3, sqy_s3;
	logic [DSQ_W-1:0]       sum_s4;

	// Output register
	logic                   rsp_valid_q;
	logic [KIND_W-1:0]      kind_out_q;
	logic [IDX_W-1:0]       index_out_q;
	logic [DIST_W-1:0]      dist_out_q;

	logic [CNT_W-1:0]       n;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_addr;
	logic [RAM_W-1:0]       ram_rdata;
	logic [IDX_W-1:0]       mod_dividend;
	logic [IDX_W-1:0]       mod_rem;
	logic                   mod_done;
	logic [CNT_W-1:0]       start_w;
	logic [CNT_W-1:0]       addr_inc;
	logic [IDX_W-1:0]       addr_next;
	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]       ax_w, ay_w;

	// Saturate the entry count at the table size
	assign n = (count_q > CNT_W'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS) : count_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			radius_q <= RADIUS_AT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COUNT:  count_q  <= cfg_wdata;
				CFG_RADIUS: radius_q <= cfg_wdata[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Waypoint table: write on accept, read at the scan address otherwise
	assign ram_we = cmd.accept && (req_type == REQ_WRITE)
		&& (CNT_W'(entry_index) < CNT_W'(MAX_WAYPOINTS));
	assign ram_addr = cmd.accept ? IDX_W'(entry_index) : addr_q;

	cwws_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_WAYPOINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({wpt_x, wpt_y}),
		.rdata(ram_rdata)
	);

	// Remainder unit, shared by the tracked index and the radius
	assign mod_dividend = cmd.mod_sel ? {{(IDX_W - RADIUS_W){1'b0}}, radius_q} : tracked_q;

	cwws_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mod_start),
		.dividend(mod_dividend),
		.divisor (n),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// Window start: (tracked mod n - radius mod n) wrapped into 0..n-1
	always_comb begin
		if (tm_q >= mod_rem) begin
			start_w = CNT_W'(tm_q) - CNT_W'(mod_rem);
		end else begin
			start_w = CNT_W'(tm_q) + n - CNT_W'(mod_rem);
		end
	end

	// Circular address advance
	assign addr_inc  = CNT_W'(addr_q) + CNT_W'(1);
	assign addr_next = (addr_inc == n) ? '0 : addr_inc[IDX_W-1:0];

	// Capture item context
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			car_x_q <= car_x;
			car_y_q <= car_y;
			if (req_type == REQ_WRITE) begin
				kind_q <= RK_WRITE;
			end else if (n == '0) begin
				kind_q <= RK_EMPTY;
			end else begin
				kind_q <= RK_FOUND;
			end
		end
		if (cmd.load_tm) begin
			tm_q <= mod_rem;
		end
	end

	// Scan address and remaining entry count
	always_ff @(posedge clk) begin
		if (cmd.init_acq) begin
			addr_q   <= '0;
			remain_q <= n;
		end else if (cmd.init_track) begin
			addr_q   <= start_w[IDX_W-1:0];
			remain_q <= CNT_W'({radius_q, 1'b1});
		end else if (cmd.issue) begin
			addr_q   <= addr_next;
			remain_q <= remain_q - CNT_W'(1);
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Absolute coordinate differences
	always_comb begin
		dx   = $signed({ram_rdata[RAM_W-1], ram_rdata[RAM_W-1:COORD_W]})
			- $signed({car_x_q[COORD_W-1], car_x_q});
		dy   = $signed({ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]})
			- $signed({car_y_q[COORD_W-1], car_y_q});
		ax_w = dx[COORD_W] ? $unsigned(-dx) : $unsigned(dx);
		ay_w = dy[COORD_W] ? $unsigned(-dy) : $unsigned(dy);
	end

	// Distance stages: difference, square, sum
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		ax_s2  <= ax_w[COORD_W-1:0];
		ay_s2  <= ay_w[COORD_W-1:0];
		idx_s3 <= idx_s2;
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
		idx_s4 <= idx_s3;
		sum_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	// Keep the first strict minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.accept) begin
			have_q <= 1'b0;
		end else if (v_s4) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && (!have_q || (sum_s4 < best_q))) begin
			best_q <= sum_s4;
			win_q  <= idx_s4;
		end
	end

	// Tracked index follows the winner of a completed search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= '0;
		end else if (cmd.finish && (kind_q == RK_FOUND)) begin
			tracked_q <= win_q;
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			kind_out_q <= kind_q;
			if (kind_q == RK_FOUND) begin
				index_out_q <= win_q;
				dist_out_q  <= DIST_W'(best_q);
			end else begin
				index_out_q <= tracked_q;
				dist_out_q  <= '0;
			end
		end
	end

	// Status to the controller
	always_comb begin
		sts.n_zero     = (n == '0);
		sts.mod_done   = mod_done;
		sts.scan_last  = (remain_q == CNT_W'(1));
		sts.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
		sts.out_free   = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid     = rsp_valid_q;
	assign result_kind   = kind_out_q;
	assign closest_index = ENTRY_W'(index_out_q);
	assign min_dist_sq   = dist_out_q;

endmodule
`default_nettype wire

/* hw/rtl/cwws_ctrl.sv */
`default_nettype none
module cwws_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	input  wire logic [cwws_pkg::REQ_W-1:0] req_type,
	input  wire cwws_pkg::sts_t             sts,
	output logic                            req_ready,
	output cwws_pkg::cmd_t                  cmd
);
	import cwws_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MOD_T  = 6'b000010,
		ST_MOD_R  = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Sequence one item: window setup for a track, scan and drain for a search, hand over
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_type)
						REQ_WRITE: begin
							cmd.accept = 1'b1;
							state_d    = ST_FINISH;
						end
						REQ_ACQUIRE: begin
							cmd.accept = 1'b1;
							if (sts.n_zero) begin
								state_d = ST_FINISH;
							end else begin
								cmd.init_acq = 1'b1;
								state_d      = ST_SCAN;
							end
						end
						REQ_TRACK: begin
							cmd.accept = 1'b1;
							if (sts.n_zero) begin
								state_d = ST_FINISH;
							end else begin
								cmd.mod_start = 1'b1;
								state_d       = ST_MOD_T;
							end
						end
						default: ;  // unused code: drop the item
					endcase
				end
			end
			ST_MOD_T: begin
				if (sts.mod_done) begin
					cmd.load_tm   = 1'b1;
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = 1'b1;
					state_d       = ST_MOD_R;
				end
			end
			ST_MOD_R: begin
				cmd.mod_sel = 1'b1;
				if (sts.mod_done) begin
					cmd.init_track = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/closest_waypoint_window_search_unit.sv */
`default_nettype none
// Nearest-waypoint search over a table of up to 4096 (x, y) entries held in one
// single-port RAM. A write item loads one entry; its acknowledgement is loaded into
// the output register from the FINISH state. An acquire item scans entries 0 to
// n-1 and a track item scans the circular window of 2R+1 entries around the
// tracked index; both read one entry per cycle through the RAM port. A track
// first runs the bit-serial remainder unit twice, to wrap the tracked index and
// the radius into the table. One item is in work at a time; a finished result
// waits in the output register while the next item is taken. The table has no
// reset and no clearing pass: search only entries that have been written.
// waypoint_count above 4096 saturates, and a search with a count of zero answers
// "table empty".
module closest_waypoint_window_search_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cwws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cwws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	cwws_req_if.sink                                 req,
	cwws_rsp_if.source                               rsp
);
	import cwws_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cwws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_type (req.req_type),
		.sts      (sts),
		.req_ready(req.ready),
		.cmd      (cmd)
	);

	cwws_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req.req_type),
		.entry_index  (req.entry_index),
		.wpt_x        (req.wpt_x),
		.wpt_y        (req.wpt_y),
		.car_x        (req.car_x),
		.car_y        (req.car_y),
		.rsp_ready    (rsp.ready),
		.cmd          (cmd),
		.sts          (sts),
		.rsp_valid    (rsp.valid),
		.result_kind  (rsp.result_kind),
		.closest_index(rsp.closest_index),
		.min_dist_sq  (rsp.min_dist_sq)
	);

endmodule
`default_nettype wire
